>>> hw/rtl/adsr_pkg.sv
// ----------------------------------------------------------------------------
// ADSR envelope level package
// Shared widths, register map, reset values and the configuration struct.
// ----------------------------------------------------------------------------
package adsr_pkg;

    localparam int DUR_BITS       = 24;
    localparam int LEVEL_BITS     = 16;
    localparam int ADDR_BITS      = 5;
    localparam int DATA_BITS      = 32;
    localparam int IDX_BITS       = 3;

    localparam int TIME_BITS_DEF  = 32;
    localparam int LEVEL_FRAC_DEF = 15;

    localparam logic [IDX_BITS-1:0] REG_ATTACK  = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_DECAY   = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_RELEASE = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_PEAK    = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_HOLD    = 3'd4;

    localparam logic [DUR_BITS-1:0]   ATTACK_RST  = 24'd4410;
    localparam logic [DUR_BITS-1:0]   DECAY_RST   = 24'd4410;
    localparam logic [DUR_BITS-1:0]   RELEASE_RST = 24'd8820;
    localparam logic [LEVEL_BITS-1:0] PEAK_RST    = 16'd32768;
    localparam logic [LEVEL_BITS-1:0] HOLD_RST    = 16'd32768;

    typedef struct packed {
        logic [DUR_BITS-1:0]   attack_ticks;
        logic [DUR_BITS-1:0]   decay_ticks;
        logic [DUR_BITS-1:0]   release_ticks;
        logic [LEVEL_BITS-1:0] peak_level;
        logic [LEVEL_BITS-1:0] hold_level;
    } cfg_t;

endpackage

>>> hw/rtl/adsr_regs.sv
// ----------------------------------------------------------------------------
// ADSR configuration registers
// APB-style register file holding the envelope durations and levels.
// ----------------------------------------------------------------------------
module adsr_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [adsr_pkg::ADDR_BITS-1:0] paddr,
    input  logic [adsr_pkg::DATA_BITS-1:0] pwdata,
    output logic [adsr_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    output adsr_pkg::cfg_t                 cfg
);

    adsr_pkg::cfg_t                  cfg_reg;
    logic [adsr_pkg::IDX_BITS-1:0]   idx;
    logic                            wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[adsr_pkg::ADDR_BITS-1:2];
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_ticks  <= adsr_pkg::ATTACK_RST;
            cfg_reg.decay_ticks   <= adsr_pkg::DECAY_RST;
            cfg_reg.release_ticks <= adsr_pkg::RELEASE_RST;
            cfg_reg.peak_level    <= adsr_pkg::PEAK_RST;
            cfg_reg.hold_level    <= adsr_pkg::HOLD_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                adsr_pkg::REG_ATTACK:
                    cfg_reg.attack_ticks  <= pwdata[adsr_pkg::DUR_BITS-1:0];
                adsr_pkg::REG_DECAY:
                    cfg_reg.decay_ticks   <= pwdata[adsr_pkg::DUR_BITS-1:0];
                adsr_pkg::REG_RELEASE:
                    cfg_reg.release_ticks <= pwdata[adsr_pkg::DUR_BITS-1:0];
                adsr_pkg::REG_PEAK:
                    cfg_reg.peak_level    <= pwdata[adsr_pkg::LEVEL_BITS-1:0];
                adsr_pkg::REG_HOLD:
                    cfg_reg.hold_level    <= pwdata[adsr_pkg::LEVEL_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            adsr_pkg::REG_ATTACK:
                prdata = adsr_pkg::DATA_BITS'(cfg_reg.attack_ticks);
            adsr_pkg::REG_DECAY:
                prdata = adsr_pkg::DATA_BITS'(cfg_reg.decay_ticks);
            adsr_pkg::REG_RELEASE:
                prdata = adsr_pkg::DATA_BITS'(cfg_reg.release_ticks);
            adsr_pkg::REG_PEAK:
                prdata = adsr_pkg::DATA_BITS'(cfg_reg.peak_level);
            adsr_pkg::REG_HOLD:
                prdata = adsr_pkg::DATA_BITS'(cfg_reg.hold_level);
            default:
                prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/adsr_div_cell.sv
// ----------------------------------------------------------------------------
// ADSR divider cell
// One restoring-division cell: settles one quotient bit and hands the
// partial remainder, divisor, quotient and sideband to the next cell.
// ----------------------------------------------------------------------------
module adsr_div_cell #(
    parameter int RW  = 40,
    parameter int DW  = 24,
    parameter int QW  = 16,
    parameter int BIT = 0,
    parameter int SBW = 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_ready,
    input  logic [RW-1:0]  up_rem,
    input  logic [DW-1:0]  up_div,
    input  logic [QW-1:0]  up_quo,
    input  logic [SBW-1:0] up_sb,
    output logic           dn_valid,
    input  logic           dn_ready,
    output logic [RW-1:0]  dn_rem,
    output logic [DW-1:0]  dn_div,
    output logic [QW-1:0]  dn_quo,
    output logic [SBW-1:0] dn_sb
);

    logic           valid_reg;
    logic [RW-1:0]  rem_reg;
    logic [DW-1:0]  div_reg;
    logic [QW-1:0]  quo_reg;
    logic [SBW-1:0] sb_reg;
    logic [RW-1:0]  trial;
    logic           take;
    logic [RW-1:0]  rem_next;
    logic [QW-1:0]  quo_next;

    assign up_ready = !valid_reg || dn_ready;
    assign trial    = RW'(up_div) << BIT;
    assign take     = up_rem >= trial;
    assign rem_next = take ? up_rem - trial : up_rem;
    assign quo_next = take ? (up_quo | (QW'(1) << BIT)) : up_quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            rem_reg <= rem_next;
            div_reg <= up_div;
            quo_reg <= quo_next;
            sb_reg  <= up_sb;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_rem   = rem_reg;
    assign dn_div   = div_reg;
    assign dn_quo   = quo_reg;
    assign dn_sb    = sb_reg;

endmodule

>>> hw/rtl/adsr_mul_div.sv
// ----------------------------------------------------------------------------
// ADSR multiply-divide chain
// Registered product followed by a row of divider cells, one quotient bit
// per cell, giving floor(mul_a * mul_b / div).
// ----------------------------------------------------------------------------
module adsr_mul_div #(
    parameter int DW  = 24,
    parameter int LW  = 16,
    parameter int SBW = 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_ready,
    input  logic [DW-1:0]  mul_a,
    input  logic [LW-1:0]  mul_b,
    input  logic [DW-1:0]  div,
    input  logic [SBW-1:0] up_sb,
    output logic           dn_valid,
    input  logic           dn_ready,
    output logic [LW-1:0]  quo,
    output logic [SBW-1:0] dn_sb
);

    localparam int RW = DW + LW;

    logic           m_valid_reg;
    logic [RW-1:0]  prod_reg;
    logic [DW-1:0]  div_reg;
    logic [SBW-1:0] sb_reg;

    logic [LW:0]    c_valid;
    logic [LW:0]    c_ready;
    logic [RW-1:0]  c_rem [LW+1];
    logic [DW-1:0]  c_div [LW+1];
    logic [LW-1:0]  c_quo [LW+1];
    logic [SBW-1:0] c_sb  [LW+1];

    assign up_ready = !m_valid_reg || c_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            m_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            prod_reg <= RW'(mul_a) * RW'(mul_b);
            div_reg  <= div;
            sb_reg   <= up_sb;
        end
    end

    assign c_valid[0] = m_valid_reg;
    assign c_rem[0]   = prod_reg;
    assign c_div[0]   = div_reg;
    assign c_quo[0]   = '0;
    assign c_sb[0]    = sb_reg;

    for (genvar k = 0; k < LW; k++)
    begin : g_cell
        adsr_div_cell #(
            .RW  (RW),
            .DW  (DW),
            .QW  (LW),
            .BIT (LW - 1 - k),
            .SBW (SBW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (c_valid[k]),
            .up_ready (c_ready[k]),
            .up_rem   (c_rem[k]),
            .up_div   (c_div[k]),
            .up_quo   (c_quo[k]),
            .up_sb    (c_sb[k]),
            .dn_valid (c_valid[k+1]),
            .dn_ready (c_ready[k+1]),
            .dn_rem   (c_rem[k+1]),
            .dn_div   (c_div[k+1]),
            .dn_quo   (c_quo[k+1]),
            .dn_sb    (c_sb[k+1])
        );
    end

    assign c_ready[LW] = dn_ready;
    assign dn_valid    = c_valid[LW];
    assign quo         = c_quo[LW];
    assign dn_sb       = c_sb[LW];

endmodule

>>> hw/rtl/adsr_envelope_level.sv
// ----------------------------------------------------------------------------
// ADSR envelope level
// Envelope amplitude of one voice from current, note-on and note-off ticks.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries now_time, on_time and off_time;
// output channel out_valid/out_ready carries level (Q1.15 at default) and
// silent. Each input item yields exactly one result item, in order.
// Durations and levels come from the APB-style port; the user must write
// them only while the block is idle, as the block does not enforce it.
// Two multiply-divide chains, each one product stage plus one divider
// cell for each of the LW = max(LEVEL_FRAC_BITS+1, 16) quotient bits, sit
// behind a lifetime stage and a phase stage, with a combine stage between
// them and an output register after. Throughput is one item per cycle
// while the receiver is ready; every stage is one cell deep.
// Reset empties the pipeline and loads the register defaults.
// When the receiver stalls, the output register holds its item and each
// stage further up keeps taking items until it is itself full, so the
// input stalls only once the whole chain is occupied.
// ----------------------------------------------------------------------------
module adsr_envelope_level #(
    parameter int TIME_BITS       = adsr_pkg::TIME_BITS_DEF,
    parameter int LEVEL_FRAC_BITS = adsr_pkg::LEVEL_FRAC_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [adsr_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [adsr_pkg::DATA_BITS-1:0]  pwdata,
    output logic [adsr_pkg::DATA_BITS-1:0]  prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [TIME_BITS-1:0]            now_time,
    input  logic [TIME_BITS-1:0]            on_time,
    input  logic [TIME_BITS-1:0]            off_time,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [adsr_pkg::LEVEL_BITS-1:0] level,
    output logic                            silent
);

    localparam int DB   = adsr_pkg::DUR_BITS;
    localparam int LW   = (LEVEL_FRAC_BITS + 1 > adsr_pkg::LEVEL_BITS) ?
                          LEVEL_FRAC_BITS + 1 : adsr_pkg::LEVEL_BITS;
    localparam int CW   = (TIME_BITS > DB) ? TIME_BITS : DB;
    localparam int SL_RAW = (2 ** LEVEL_FRAC_BITS) / 10000;
    localparam int SILENT_LIMIT = (SL_RAW > 0) ? SL_RAW : 1;
    localparam int SB1W = LW + DB + 3;
    localparam int SB2W = LW + 2;

    localparam logic [LW-1:0] ONE_L = LW'(1) << LEVEL_FRAC_BITS;
    localparam logic [LW-1:0] SIL_L = LW'(SILENT_LIMIT);

    adsr_pkg::cfg_t cfg;

    logic [DB-1:0] a_eff;
    logic [DB-1:0] d_eff;
    logic [DB-1:0] rel_eff;
    logic [LW-1:0] peak_x;
    logic [LW-1:0] hold_x;
    logic [LW-1:0] pk;
    logic [LW-1:0] hd;

    // stage 0: lifetime and ticks since release
    logic                 s0_valid_reg;
    logic                 s0_held_reg;
    logic [TIME_BITS-1:0] s0_life_reg;
    logic                 s0_e_ge_reg;
    logic [DB-1:0]        s0_e_lo_reg;
    logic                 s0_ready;
    logic                 held_in;
    logic [TIME_BITS-1:0] life_in;
    logic [TIME_BITS-1:0] e_raw;
    logic [CW-1:0]        e_c;

    // stage 1: envelope phase
    logic                 s1_valid_reg;
    logic [DB-1:0]        s1_mul_a_reg;
    logic [LW-1:0]        s1_mul_b_reg;
    logic [DB-1:0]        s1_div_reg;
    logic [SB1W-1:0]      s1_sb_reg;
    logic                 s1_ready;
    logic [CW-1:0]        life_c;
    logic [CW-1:0]        x_c;
    logic                 att;
    logic                 dec;
    logic                 down;
    logic [DB-1:0]        mul_a_next;
    logic [LW-1:0]        mul_b_next;
    logic [DB-1:0]        div_next;
    logic [LW-1:0]        base_next;
    logic                 neg_next;

    logic                 md1_ready;
    logic                 md1_valid;
    logic [LW-1:0]        md1_quo;
    logic [SB1W-1:0]      md1_sb;

    // stage 2: key-down level, reached at release or current while held
    logic                 s2_valid_reg;
    logic                 s2_held_reg;
    logic                 s2_e_ge_reg;
    logic [DB-1:0]        s2_e_lo_reg;
    logic [LW-1:0]        s2_r_reg;
    logic                 s2_ready;
    logic [LW-1:0]        base1;
    logic                 neg1;
    logic [LW-1:0]        r_next;

    logic                 md2_ready;
    logic                 md2_valid;
    logic [LW-1:0]        md2_quo;
    logic [SB2W-1:0]      md2_sb;

    // stage 3: output register
    logic                          out_valid_reg;
    logic [adsr_pkg::LEVEL_BITS-1:0] level_reg;
    logic                          silent_reg;
    logic                          s3_ready;
    logic [LW-1:0]                 r2;
    logic [LW-1:0]                 lvl;
    logic                          sil;

    adsr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign a_eff   = (cfg.attack_ticks  == '0) ? DB'(1) : cfg.attack_ticks;
    assign d_eff   = (cfg.decay_ticks   == '0) ? DB'(1) : cfg.decay_ticks;
    assign rel_eff = (cfg.release_ticks == '0) ? DB'(1) : cfg.release_ticks;
    assign peak_x  = LW'(cfg.peak_level);
    assign hold_x  = LW'(cfg.hold_level);
    assign pk      = (peak_x > ONE_L) ? ONE_L : peak_x;
    assign hd      = (hold_x > ONE_L) ? ONE_L : hold_x;

    // ---- stage 0 ----
    assign held_in  = on_time > off_time;
    assign life_in  = held_in ? ((now_time >= on_time) ? now_time - on_time : '0)
                              : off_time - on_time;
    assign e_raw    = (now_time >= off_time) ? now_time - off_time : '0;
    assign e_c      = CW'(e_raw);
    assign s0_ready = !s0_valid_reg || s1_ready;
    assign in_ready = s0_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_ready)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready && in_valid)
        begin
            s0_held_reg <= held_in;
            s0_life_reg <= life_in;
            s0_e_ge_reg <= e_c >= CW'(rel_eff);
            s0_e_lo_reg <= e_c[DB-1:0];
        end
    end

    // ---- stage 1 ----
    assign life_c   = CW'(s0_life_reg);
    assign att      = life_c <= CW'(a_eff);
    assign x_c      = life_c - CW'(a_eff);
    assign dec      = x_c <= CW'(d_eff);
    assign down     = hd < pk;
    assign s1_ready = !s1_valid_reg || md1_ready;

    always_comb
    begin
        priority if (att)
        begin
            mul_a_next = life_c[DB-1:0];
            mul_b_next = pk;
            div_next   = a_eff;
            base_next  = '0;
            neg_next   = 1'b0;
        end
        else if (dec)
        begin
            mul_a_next = x_c[DB-1:0];
            mul_b_next = down ? pk - hd : hd - pk;
            div_next   = d_eff;
            base_next  = pk;
            neg_next   = down;
        end
        else
        begin
            mul_a_next = '0;
            mul_b_next = '0;
            div_next   = d_eff;
            base_next  = hd;
            neg_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s0_valid_reg)
        begin
            s1_mul_a_reg <= mul_a_next;
            s1_mul_b_reg <= mul_b_next;
            s1_div_reg   <= div_next;
            s1_sb_reg    <= {s0_held_reg, s0_e_ge_reg, s0_e_lo_reg, base_next, neg_next};
        end
    end

    adsr_mul_div #(
        .DW  (DB),
        .LW  (LW),
        .SBW (SB1W)
    ) u_held_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid_reg),
        .up_ready (md1_ready),
        .mul_a    (s1_mul_a_reg),
        .mul_b    (s1_mul_b_reg),
        .div      (s1_div_reg),
        .up_sb    (s1_sb_reg),
        .dn_valid (md1_valid),
        .dn_ready (s2_ready),
        .quo      (md1_quo),
        .dn_sb    (md1_sb)
    );

    // ---- stage 2 ----
    assign neg1     = md1_sb[0];
    assign base1    = md1_sb[LW:1];
    assign r_next   = neg1 ? base1 - md1_quo : base1 + md1_quo;
    assign s2_ready = !s2_valid_reg || md2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= md1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && md1_valid)
        begin
            s2_r_reg    <= r_next;
            s2_e_lo_reg <= md1_sb[LW+DB:LW+1];
            s2_e_ge_reg <= md1_sb[LW+DB+1];
            s2_held_reg <= md1_sb[LW+DB+2];
        end
    end

    adsr_mul_div #(
        .DW  (DB),
        .LW  (LW),
        .SBW (SB2W)
    ) u_rel_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid_reg),
        .up_ready (md2_ready),
        .mul_a    (s2_held_reg ? '0 : s2_e_lo_reg),
        .mul_b    (s2_r_reg),
        .div      (rel_eff),
        .up_sb    ({s2_held_reg, s2_e_ge_reg, s2_r_reg}),
        .dn_valid (md2_valid),
        .dn_ready (s3_ready),
        .quo      (md2_quo),
        .dn_sb    (md2_sb)
    );

    // ---- stage 3 ----
    assign r2       = md2_sb[LW-1:0];
    assign lvl      = md2_sb[LW+1] ? r2 : (md2_sb[LW] ? '0 : r2 - md2_quo);
    assign sil      = lvl < SIL_L;
    assign s3_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            out_valid_reg <= md2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && md2_valid)
        begin
            level_reg  <= sil ? '0 : lvl[adsr_pkg::LEVEL_BITS-1:0];
            silent_reg <= sil;
        end
    end

    assign out_valid = out_valid_reg;
    assign level     = level_reg;
    assign silent    = silent_reg;

    a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && silent |-> level == '0)
        else $error("silent result with nonzero level");

    a_release_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> s2_r_reg <= ONE_L)
        else $error("level at release above one");

    a_stage0_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s0_valid_reg && !s1_ready |=> s0_valid_reg && $stable(s0_life_reg))
        else $error("lifetime stage lost its item while stalled");

endmodule

>>> tb/sv/tb_adsr_envelope_level.sv
// ----------------------------------------------------------------------------
// ADSR envelope level testbench
// Drives note timing items through the valid/ready input channel and checks
// every level and silent flag against an in-bench envelope predictor. The
// register port is reprogrammed between tests while the pipeline is empty:
// reset values, zero durations, levels above one, short and long envelopes,
// rising and falling decay and random settings. The sender works in bursts
// and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_adsr_envelope_level;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TB_TIME_BITS   = adsr_pkg::TIME_BITS_DEF;
    localparam int PIPE_LATENCY   = 38;
    localparam int CYCLE_LIMIT    = 400000;
    localparam longint unsigned LEVEL_ONE    = 64'd1 << adsr_pkg::LEVEL_FRAC_DEF;
    localparam longint unsigned SILENT_FLOOR =
        (LEVEL_ONE / 10000 > 0) ? LEVEL_ONE / 10000 : 64'd1;

    typedef struct packed {
        logic [adsr_pkg::LEVEL_BITS-1:0] level;
        logic                            silent;
    } envelope_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            psel      = 1'b0;
    logic                            penable   = 1'b0;
    logic                            pwrite    = 1'b0;
    logic [adsr_pkg::ADDR_BITS-1:0]  paddr     = '0;
    logic [adsr_pkg::DATA_BITS-1:0]  pwdata    = '0;
    logic [adsr_pkg::DATA_BITS-1:0]  prdata;
    logic                            pready;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    logic [TB_TIME_BITS-1:0]         now_time  = '0;
    logic [TB_TIME_BITS-1:0]         on_time   = '0;
    logic [TB_TIME_BITS-1:0]         off_time  = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [adsr_pkg::LEVEL_BITS-1:0] level;
    logic                            silent;

    adsr_pkg::cfg_t model_cfg;
    envelope_t      pending_levels[$];
    int unsigned    fail_count  = 0;
    int unsigned    cycle_count = 0;
    int unsigned    burst_left  = 0;
    int unsigned    sink_span   = 0;
    int unsigned    sink_mode   = 0;

    adsr_envelope_level dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .now_time  (now_time),
        .on_time   (on_time),
        .off_time  (off_time),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .level     (level),
        .silent    (silent)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** adsr_envelope_level: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (sink_span == 0)
        begin
            sink_mode <= $urandom_range(0, 3);
            sink_span <= $urandom_range(8, 160);
        end
        else
        begin
            sink_span <= sink_span - 1;
        end
        case (sink_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= (cycle_count[2:0] != 3'd0);
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(negedge clk)
    begin : check_result
        envelope_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_levels.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("ERROR: unexpected item level=%0d silent=%0b", level, silent);
            end
            else
            begin
                want = pending_levels.pop_front();
                if (want.level !== level || want.silent !== silent)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: level exp=%0d got=%0d, silent exp=%0b got=%0b",
                                 want.level, level, want.silent, silent);
                end
            end
        end
    end

    function automatic longint unsigned at_least_one(input longint unsigned d);
        return (d == 0) ? 64'd1 : d;
    endfunction

    function automatic longint unsigned cap_level(input longint unsigned v);
        return (v > LEVEL_ONE) ? LEVEL_ONE : v;
    endfunction

    function automatic longint unsigned key_down_level(input longint unsigned life);
        longint unsigned a, d, pk, hd, x;
        a  = at_least_one(64'(model_cfg.attack_ticks));
        d  = at_least_one(64'(model_cfg.decay_ticks));
        pk = cap_level(64'(model_cfg.peak_level));
        hd = cap_level(64'(model_cfg.hold_level));
        if (life <= a)
            return (life * pk) / a;
        x = life - a;
        if (x <= d)
        begin
            if (hd >= pk)
                return pk + ((hd - pk) * x) / d;
            return pk - ((pk - hd) * x) / d;
        end
        return hd;
    endfunction

    function automatic envelope_t predict_envelope(input logic [TB_TIME_BITS-1:0] t_now,
                                                   input logic [TB_TIME_BITS-1:0] t_on,
                                                   input logic [TB_TIME_BITS-1:0] t_off);
        longint unsigned lvl, reached, rel, since_off, life;
        envelope_t       res;
        if (t_on > t_off)
        begin
            life = (t_now >= t_on) ? longint'(t_now) - longint'(t_on) : 64'd0;
            lvl  = key_down_level(life);
        end
        else
        begin
            reached   = key_down_level(longint'(t_off) - longint'(t_on));
            rel       = at_least_one(64'(model_cfg.release_ticks));
            since_off = (t_now >= t_off) ? longint'(t_now) - longint'(t_off) : 64'd0;
            if (since_off >= rel)
                lvl = 0;
            else
                lvl = reached - (reached * since_off) / rel;
        end
        if (lvl < SILENT_FLOOR)
        begin
            res.level  = '0;
            res.silent = 1'b1;
        end
        else
        begin
            res.level  = lvl[adsr_pkg::LEVEL_BITS-1:0];
            res.silent = 1'b0;
        end
        return res;
    endfunction

    task automatic send_envelope_item(input logic [TB_TIME_BITS-1:0] t_now,
                                      input logic [TB_TIME_BITS-1:0] t_on,
                                      input logic [TB_TIME_BITS-1:0] t_off);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        now_time <= t_now;
        on_time  <= t_on;
        off_time <= t_off;
        do @(negedge clk); while (!in_ready);
        pending_levels.push_back(predict_envelope(t_now, t_on, t_off));
        @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_levels.size() != 0);
    endtask

    task automatic write_reg(input logic [adsr_pkg::IDX_BITS-1:0]  idx,
                             input logic [adsr_pkg::DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(negedge clk); while (!pready);
        @(posedge clk);
        case (idx)
            adsr_pkg::REG_ATTACK:
                model_cfg.attack_ticks  = value[adsr_pkg::DUR_BITS-1:0];
            adsr_pkg::REG_DECAY:
                model_cfg.decay_ticks   = value[adsr_pkg::DUR_BITS-1:0];
            adsr_pkg::REG_RELEASE:
                model_cfg.release_ticks = value[adsr_pkg::DUR_BITS-1:0];
            adsr_pkg::REG_PEAK:
                model_cfg.peak_level    = value[adsr_pkg::LEVEL_BITS-1:0];
            adsr_pkg::REG_HOLD:
                model_cfg.hold_level    = value[adsr_pkg::LEVEL_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic configure_envelope(input logic [adsr_pkg::DUR_BITS-1:0]   a_ticks,
                                      input logic [adsr_pkg::DUR_BITS-1:0]   d_ticks,
                                      input logic [adsr_pkg::DUR_BITS-1:0]   r_ticks,
                                      input logic [adsr_pkg::LEVEL_BITS-1:0] peak,
                                      input logic [adsr_pkg::LEVEL_BITS-1:0] sustain);
        drain_results();
        write_reg(adsr_pkg::REG_ATTACK, adsr_pkg::DATA_BITS'(a_ticks));
        write_reg(adsr_pkg::REG_DECAY, adsr_pkg::DATA_BITS'(d_ticks));
        write_reg(adsr_pkg::REG_RELEASE, adsr_pkg::DATA_BITS'(r_ticks));
        write_reg(adsr_pkg::REG_PEAK, adsr_pkg::DATA_BITS'(peak));
        write_reg(adsr_pkg::REG_HOLD, adsr_pkg::DATA_BITS'(sustain));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_random_items(input int count);
        int unsigned span, rel_span, kind;
        logic [TB_TIME_BITS-1:0] t_now, t_on, t_off;
        span     = 32'(at_least_one(64'(model_cfg.attack_ticks)) +
                       at_least_one(64'(model_cfg.decay_ticks)));
        rel_span = 32'(at_least_one(64'(model_cfg.release_ticks)));
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                drain_results();
            kind = $urandom_range(0, 9);
            t_on = $urandom;
            if (kind == 0)
            begin
                t_now = $urandom;
                t_off = $urandom;
            end
            else if (kind <= 4)
            begin
                t_off = (t_on == 0) ? '0 : $urandom_range(0, t_on - 1);
                if ($urandom_range(0, 7) == 0)
                    t_now = t_on - $urandom_range(1, 100);
                else
                    t_now = t_on + $urandom_range(0, span + span / 4 + 2);
            end
            else
            begin
                t_off = t_on + $urandom_range(0, span + span / 4 + 2);
                if ($urandom_range(0, 7) == 0)
                    t_now = t_off - $urandom_range(1, 100);
                else
                    t_now = t_off + $urandom_range(0, rel_span + rel_span / 4 + 2);
            end
            send_envelope_item(t_now, t_on, t_off);
        end
    endtask

    task automatic test_reset_defaults();
        send_envelope_item(32'd0, 32'd0, 32'd0);
        send_envelope_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_envelope_item(32'd5, 32'd100, 32'd0);
        send_envelope_item(32'd3205, 32'd1000, 32'd0);
        send_envelope_item(32'd5410, 32'd1000, 32'd0);
        send_envelope_item(32'd7615, 32'd1000, 32'd0);
        send_envelope_item(32'hFFFF_FFFF, 32'd1, 32'd0);
        send_envelope_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        send_envelope_item(32'd10, 32'd0, 32'd3000);
        send_envelope_item(32'd7410, 32'd0, 32'd3000);
        send_envelope_item(32'd11818, 32'd0, 32'd3000);
        send_envelope_item(32'd11819, 32'd0, 32'd3000);
        send_envelope_item(32'd11820, 32'd0, 32'd3000);
        send_envelope_item(32'd500, 32'd200, 32'd200);
        send_envelope_item(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        send_envelope_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_envelope_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    endtask

    task automatic test_zero_durations_over_one();
        configure_envelope(24'd0, 24'd0, 24'd0, 16'hFFFF, 16'd20000);
        for (int life = 0; life < 4; life++)
        begin
            send_envelope_item(32'd100 + life, 32'd100, 32'd99);
            send_envelope_item(32'd200 + life, 32'd100, 32'd100 + life);
        end
        configure_envelope(24'd0, 24'd0, 24'd0, 16'd12000, 16'd40000);
        for (int life = 0; life < 4; life++)
            send_envelope_item(32'd100 + life, 32'd100, 32'd99);
        send_envelope_item(32'd102, 32'd100, 32'd102);
        send_random_items(150);
    endtask

    task automatic test_short_envelope();
        configure_envelope(24'd10, 24'd20, 24'd30, 16'd30000, 16'd9000);
        send_random_items(350);
    endtask

    task automatic test_rising_decay();
        configure_envelope(24'd300, 24'd700, 24'd1000, 16'd5000, 16'd32768);
        send_random_items(350);
    endtask

    task automatic test_longest_durations();
        configure_envelope(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 16'd0, 16'd32768);
        send_random_items(300);
    endtask

    task automatic test_shortest_durations();
        configure_envelope(24'd1, 24'd1, 24'd1, 16'd32768, 16'd0);
        send_random_items(100);
    endtask

    task automatic test_random_settings();
        logic [adsr_pkg::DUR_BITS-1:0]   dur[3];
        logic [adsr_pkg::LEVEL_BITS-1:0] lvl[2];
        for (int round = 0; round < 4; round++)
        begin
            foreach (dur[k])
                dur[k] = adsr_pkg::DUR_BITS'(($urandom_range(0, 3) == 0) ?
                                             $urandom_range(1, 24'hFF_FFFF) :
                                             $urandom_range(1, 5000));
            foreach (lvl[k])
                lvl[k] = adsr_pkg::LEVEL_BITS'(($urandom_range(0, 4) == 0) ?
                                               $urandom_range(0, 16'hFFFF) :
                                               $urandom_range(0, 32768));
            configure_envelope(dur[0], dur[1], dur[2], lvl[0], lvl[1]);
            send_random_items(150);
        end
    endtask

    initial
    begin
        model_cfg.attack_ticks  = adsr_pkg::ATTACK_RST;
        model_cfg.decay_ticks   = adsr_pkg::DECAY_RST;
        model_cfg.release_ticks = adsr_pkg::RELEASE_RST;
        model_cfg.peak_level    = adsr_pkg::PEAK_RST;
        model_cfg.hold_level    = adsr_pkg::HOLD_RST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_zero_durations_over_one();
        test_short_envelope();
        test_rising_decay();
        test_longest_durations();
        test_shortest_durations();
        test_random_settings();

        drain_results();
        repeat (2 * PIPE_LATENCY) @(posedge clk);
        if (fail_count == 0 && pending_levels.size() == 0)
            $display("** adsr_envelope_level: PASSED **");
        else
            $display("** adsr_envelope_level: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/adsr_pkg.sv
hw/rtl/adsr_regs.sv
hw/rtl/adsr_div_cell.sv
hw/rtl/adsr_mul_div.sv
hw/rtl/adsr_envelope_level.sv
tb/sv/tb_adsr_envelope_level.sv
